// ----- hdl/tves_pkg.sv -----
// Package for the T-vertex elimination splitter: pattern codes, vertex
// selector types and the table of primitive templates for each pattern.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tves_pkg;

    typedef enum logic [3:0] {
        PAT_TRI0      = 4'd0,
        PAT_TRI1      = 4'd1,
        PAT_TRI2      = 4'd2,
        PAT_TRI3      = 4'd3,
        PAT_QUAD0     = 4'd4,
        PAT_QUAD1     = 4'd5,
        PAT_QUAD2_ADJ = 4'd6,
        PAT_QUAD2_OPP = 4'd7,
        PAT_QUAD3     = 4'd8,
        PAT_QUAD4     = 4'd9
    } t_pattern;

    localparam int PATTERN_BITS = $bits(t_pattern);
    localparam int STEP_BITS    = 3;

    typedef logic [STEP_BITS-1:0] t_step;

    typedef struct packed {
        logic       is_mid;
        logic [1:0] idx;
    } t_vsel;

    typedef struct packed {
        logic  is_quad;
        logic  last;
        t_vsel sel_a;
        t_vsel sel_b;
        t_vsel sel_c;
        t_vsel sel_d;
    } t_prim_tmpl;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

    localparam t_vsel SEL_V0 = '{is_mid: 1'b0, idx: 2'd0};
    localparam t_vsel SEL_V1 = '{is_mid: 1'b0, idx: 2'd1};
    localparam t_vsel SEL_V2 = '{is_mid: 1'b0, idx: 2'd2};
    localparam t_vsel SEL_V3 = '{is_mid: 1'b0, idx: 2'd3};
    localparam t_vsel SEL_M0 = '{is_mid: 1'b1, idx: 2'd0};
    localparam t_vsel SEL_M1 = '{is_mid: 1'b1, idx: 2'd1};
    localparam t_vsel SEL_M2 = '{is_mid: 1'b1, idx: 2'd2};
    localparam t_vsel SEL_M3 = '{is_mid: 1'b1, idx: 2'd3};

    function automatic t_prim_tmpl tri_t(logic l, t_vsel a, t_vsel b, t_vsel c);
        tri_t = '{is_quad: 1'b0, last: l, sel_a: a, sel_b: b, sel_c: c, sel_d: SEL_V0};
    endfunction

    function automatic t_prim_tmpl quad_t(logic l, t_vsel a, t_vsel b, t_vsel c,
                                          t_vsel d);
        quad_t = '{is_quad: 1'b1, last: l, sel_a: a, sel_b: b, sel_c: c, sel_d: d};
    endfunction

    // Vertex selectors refer to corners and midpoints already rotated so
    // that the pattern's reference edge is edge zero. In patterns with several
    // steps, the final step sits in the default arm.
    function automatic t_prim_tmpl prim_template(t_pattern p, t_step s);
        t_prim_tmpl t;
        t = tri_t(1'b1, SEL_V0, SEL_V1, SEL_V2);
        unique case (p)
            PAT_TRI0: begin
                t = tri_t(1'b1, SEL_V0, SEL_V1, SEL_V2);
            end
            PAT_TRI1: begin
                unique case (s)
                    3'd0:    t = tri_t(1'b0, SEL_M0, SEL_V2, SEL_V0);
                    default: t = tri_t(1'b1, SEL_M0, SEL_V1, SEL_V2);
                endcase
            end
            PAT_TRI2: begin
                unique case (s)
                    3'd0:    t = tri_t(1'b0, SEL_M1, SEL_V0, SEL_V1);
                    3'd1:    t = tri_t(1'b0, SEL_M1, SEL_M2, SEL_V0);
                    default: t = tri_t(1'b1, SEL_M1, SEL_V2, SEL_M2);
                endcase
            end
            PAT_TRI3: begin
                unique case (s)
                    3'd0:    t = tri_t(1'b0, SEL_V0, SEL_M0, SEL_M2);
                    3'd1:    t = tri_t(1'b0, SEL_V1, SEL_M1, SEL_M0);
                    3'd2:    t = tri_t(1'b0, SEL_V2, SEL_M2, SEL_M1);
                    default: t = tri_t(1'b1, SEL_M0, SEL_M1, SEL_M2);
                endcase
            end
            PAT_QUAD0: begin
                t = quad_t(1'b1, SEL_V0, SEL_V1, SEL_V2, SEL_V3);
            end
            PAT_QUAD1: begin
                unique case (s)
                    3'd0:    t = tri_t(1'b0, SEL_M0, SEL_V3, SEL_V0);
                    3'd1:    t = tri_t(1'b0, SEL_M0, SEL_V2, SEL_V3);
                    default: t = tri_t(1'b1, SEL_M0, SEL_V1, SEL_V2);
                endcase
            end
            PAT_QUAD2_ADJ: begin
                unique case (s)
                    3'd0:    t = tri_t(1'b0, SEL_M0, SEL_V1, SEL_M1);
                    3'd1:    t = tri_t(1'b0, SEL_M1, SEL_V2, SEL_V3);
                    3'd2:    t = tri_t(1'b0, SEL_V3, SEL_M0, SEL_M1);
                    default: t = tri_t(1'b1, SEL_V3, SEL_V0, SEL_M0);
                endcase
            end
            PAT_QUAD2_OPP: begin
                unique case (s)
                    3'd0:    t = quad_t(1'b0, SEL_V0, SEL_M0, SEL_M2, SEL_V3);
                    default: t = quad_t(1'b1, SEL_M0, SEL_V1, SEL_V2, SEL_M2);
                endcase
            end
            PAT_QUAD3: begin
                unique case (s)
                    3'd0:    t = quad_t(1'b0, SEL_V0, SEL_V1, SEL_M1, SEL_M3);
                    3'd1:    t = tri_t(1'b0, SEL_M1, SEL_V2, SEL_M2);
                    3'd2:    t = tri_t(1'b0, SEL_M2, SEL_V3, SEL_M3);
                    default: t = tri_t(1'b1, SEL_M1, SEL_M2, SEL_M3);
                endcase
            end
            PAT_QUAD4: begin
                unique case (s)
                    3'd0:    t = tri_t(1'b0, SEL_V0, SEL_M0, SEL_M3);
                    3'd1:    t = tri_t(1'b0, SEL_V1, SEL_M1, SEL_M0);
                    3'd2:    t = tri_t(1'b0, SEL_V2, SEL_M2, SEL_M1);
                    3'd3:    t = tri_t(1'b0, SEL_V3, SEL_M3, SEL_M2);
                    default: t = quad_t(1'b1, SEL_M0, SEL_M1, SEL_M2, SEL_M3);
                endcase
            end
            default: begin
                t = tri_t(1'b1, SEL_V0, SEL_V1, SEL_V2);
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tvertex_elimination_split_top.sv -----
// T-vertex elimination splitter: splits a triangle or quadrilateral with
// marked edge midpoints into a run of T-vertex-free primitives.
// Input channel: i_valid with o_stall; a transfer takes place on a rising
// edge with i_valid high and o_stall low. Each transfer carries the shape,
// the edge mask, four corner ids and four midpoint ids.
// Output channel: o_valid with i_stall; each transfer carries one triangle
// or quadrilateral, and o_last marks the final primitive of an element.
// An element yields one to five primitives, one per cycle while i_stall is
// low; the sequencer steps through the pattern table and takes the next
// element from the queue only after the final primitive of the current one.
// An accepted element is held in the queue, and each primitive is registered.
// A two-entry queue sits between the classifier and the sequencer, so input
// transfers continue while results wait; o_stall rises only when it is full.
// While i_stall is high the output register holds its primitive unchanged.
// Reset is synchronous and active low; it empties the queue and clears the
// output valid flag.
// Depends on tves_pkg, tves_front, tves_queue and tves_back.
`timescale 1ns / 1ps
`default_nettype none

module tvertex_elimination_split_top #(
    parameter int VERTEX_ID_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_is_quad,
    input  wire logic [3:0]                i_edge_mask,
    input  wire logic [VERTEX_ID_BITS-1:0] i_corner_id_0,
    input  wire logic [VERTEX_ID_BITS-1:0] i_corner_id_1,
    input  wire logic [VERTEX_ID_BITS-1:0] i_corner_id_2,
    input  wire logic [VERTEX_ID_BITS-1:0] i_corner_id_3,
    input  wire logic [VERTEX_ID_BITS-1:0] i_mid_id_0,
    input  wire logic [VERTEX_ID_BITS-1:0] i_mid_id_1,
    input  wire logic [VERTEX_ID_BITS-1:0] i_mid_id_2,
    input  wire logic [VERTEX_ID_BITS-1:0] i_mid_id_3,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_prim_is_quad,
    output logic      [VERTEX_ID_BITS-1:0] o_vert_a,
    output logic      [VERTEX_ID_BITS-1:0] o_vert_b,
    output logic      [VERTEX_ID_BITS-1:0] o_vert_c,
    output logic      [VERTEX_ID_BITS-1:0] o_vert_d,
    output logic                           o_last
);

    localparam int DATA_BITS = 8 * VERTEX_ID_BITS + tves_pkg::PATTERN_BITS;

    logic [3:0][VERTEX_ID_BITS-1:0] in_corners;
    logic [3:0][VERTEX_ID_BITS-1:0] in_mids;
    logic [3:0][VERTEX_ID_BITS-1:0] f_corners;
    logic [3:0][VERTEX_ID_BITS-1:0] f_mids;
    tves_pkg::t_pattern             f_pattern;
    logic [DATA_BITS-1:0]           q_wdata;
    logic [DATA_BITS-1:0]           q_rdata;
    tves_pkg::t_q_status            q_status;
    logic                           q_push;
    logic                           q_pop;

    assign in_corners = {i_corner_id_3, i_corner_id_2, i_corner_id_1, i_corner_id_0};
    assign in_mids    = {i_mid_id_3, i_mid_id_2, i_mid_id_1, i_mid_id_0};

    tves_front #(
        .VERTEX_ID_BITS(VERTEX_ID_BITS)
    ) u_front (
        .i_is_quad  (i_is_quad),
        .i_edge_mask(i_edge_mask),
        .i_corners  (in_corners),
        .i_mids     (in_mids),
        .o_pattern  (f_pattern),
        .o_corners  (f_corners),
        .o_mids     (f_mids)
    );

    assign q_wdata = {f_mids, f_corners, f_pattern};
    assign q_push  = i_valid && !q_status.full;
    assign o_stall = q_status.full;

    tves_queue #(
        .DATA_BITS(DATA_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_status(q_status)
    );

    tves_back #(
        .VERTEX_ID_BITS(VERTEX_ID_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_data        (q_rdata),
        .o_pop         (q_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_prim_is_quad(o_prim_is_quad),
        .o_vert_a      (o_vert_a),
        .o_vert_b      (o_vert_b),
        .o_vert_c      (o_vert_c),
        .o_vert_d      (o_vert_d),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ----- hdl/tves_front.sv -----
// Front end of the T-vertex splitter: classifies an element into a
// splitting pattern and rotates its corners and midpoints to that pattern.
// Depends on tves_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tves_front #(
    parameter int VERTEX_ID_BITS = 16
) (
    input  wire logic                           i_is_quad,
    input  wire logic [3:0]                     i_edge_mask,
    input  wire logic [3:0][VERTEX_ID_BITS-1:0] i_corners,
    input  wire logic [3:0][VERTEX_ID_BITS-1:0] i_mids,
    output tves_pkg::t_pattern                  o_pattern,
    output logic      [3:0][VERTEX_ID_BITS-1:0] o_corners,
    output logic      [3:0][VERTEX_ID_BITS-1:0] o_mids
);

    logic [3:0] eff_mask;
    logic [2:0] n_marked;
    logic [1:0] first_set;
    logic [1:0] first_clear;
    logic [1:0] adj_prev;
    logic [1:0] rot;

    assign eff_mask = {i_is_quad & i_edge_mask[3], i_edge_mask[2:0]};
    assign n_marked = {2'b00, eff_mask[0]} + {2'b00, eff_mask[1]}
                    + {2'b00, eff_mask[2]} + {2'b00, eff_mask[3]};

    always_comb begin
        priority if (eff_mask[0]) first_set = 2'd0;
        else if (eff_mask[1])     first_set = 2'd1;
        else if (eff_mask[2])     first_set = 2'd2;
        else                      first_set = 2'd3;
        priority if (!eff_mask[0]) first_clear = 2'd0;
        else if (!eff_mask[1])     first_clear = 2'd1;
        else if (!eff_mask[2])     first_clear = 2'd2;
        else                       first_clear = 2'd3;
    end

    assign adj_prev = first_set + 2'd3;

    always_comb begin
        o_pattern = tves_pkg::PAT_TRI0;
        rot       = 2'd0;
        if (!i_is_quad) begin
            unique case (n_marked)
                3'd0: o_pattern = tves_pkg::PAT_TRI0;
                3'd1: begin
                    o_pattern = tves_pkg::PAT_TRI1;
                    rot       = first_set;
                end
                3'd2: begin
                    o_pattern = tves_pkg::PAT_TRI2;
                    rot       = first_clear;
                end
                default: o_pattern = tves_pkg::PAT_TRI3;
            endcase
        end else begin
            unique case (n_marked)
                3'd0: o_pattern = tves_pkg::PAT_QUAD0;
                3'd1: begin
                    o_pattern = tves_pkg::PAT_QUAD1;
                    rot       = first_set;
                end
                3'd2: begin
                    if (eff_mask == 4'b0101 || eff_mask == 4'b1010) begin
                        o_pattern = tves_pkg::PAT_QUAD2_OPP;
                        rot       = first_set;
                    end else begin
                        o_pattern = tves_pkg::PAT_QUAD2_ADJ;
                        rot       = eff_mask[adj_prev] ? adj_prev : first_set;
                    end
                end
                3'd3: begin
                    o_pattern = tves_pkg::PAT_QUAD3;
                    rot       = first_clear;
                end
                default: o_pattern = tves_pkg::PAT_QUAD4;
            endcase
        end
    end

    always_comb begin
        logic [2:0] sum;
        logic [1:0] src;
        for (int i = 0; i < 4; i++) begin
            sum = {1'b0, rot} + 3'(i);
            if (i_is_quad) begin
                src = sum[1:0];
            end else if (sum >= 3'd3) begin
                src = 2'(sum - 3'd3);
            end else begin
                src = sum[1:0];
            end
            o_corners[i] = i_corners[src];
            o_mids[i]    = i_mids[src];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tves_queue.sv -----
// Two-entry queue of classified elements between the front and back ends.
// Depends on tves_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tves_queue #(
    parameter int DATA_BITS = 132
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [DATA_BITS-1:0] i_data,
    input  wire logic                 i_pop,
    output logic      [DATA_BITS-1:0] o_data,
    output tves_pkg::t_q_status       o_status
);

    logic [1:0][DATA_BITS-1:0] r_mem;
    logic                      r_wr_ptr;
    logic                      r_rd_ptr;
    logic [1:0]                r_count;
    logic                      n_wr_ptr;
    logic                      n_rd_ptr;
    logic [1:0]                n_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_status.full      = (r_count == 2'd2);
    assign o_status.not_empty = (r_count != 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.not_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tves_back.sv -----
// Back end of the T-vertex splitter: steps through the head element's
// primitive templates and drives the registered result channel.
// Depends on tves_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tves_back #(
    parameter int VERTEX_ID_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire tves_pkg::t_q_status                   i_q_status,
    input  wire logic [8*VERTEX_ID_BITS+tves_pkg::PATTERN_BITS-1:0] i_data,
    output logic                                       o_pop,
    input  wire logic                                  i_stall,
    output logic                                       o_valid,
    output logic                                       o_prim_is_quad,
    output logic      [VERTEX_ID_BITS-1:0]             o_vert_a,
    output logic      [VERTEX_ID_BITS-1:0]             o_vert_b,
    output logic      [VERTEX_ID_BITS-1:0]             o_vert_c,
    output logic      [VERTEX_ID_BITS-1:0]             o_vert_d,
    output logic                                       o_last
);

    localparam int PB = tves_pkg::PATTERN_BITS;
    localparam int VB = 4 * VERTEX_ID_BITS;

    tves_pkg::t_pattern               pattern;
    logic [3:0][VERTEX_ID_BITS-1:0]   corners;
    logic [3:0][VERTEX_ID_BITS-1:0]   mids;
    tves_pkg::t_prim_tmpl             tmpl;
    tves_pkg::t_step                  r_step;
    tves_pkg::t_step                  n_step;
    logic                             load;

    logic                             r_valid;
    logic                             r_quad;
    logic [VERTEX_ID_BITS-1:0]        r_a;
    logic [VERTEX_ID_BITS-1:0]        r_b;
    logic [VERTEX_ID_BITS-1:0]        r_c;
    logic [VERTEX_ID_BITS-1:0]        r_d;
    logic                             r_last;

    function automatic logic [VERTEX_ID_BITS-1:0] pick(
        tves_pkg::t_vsel                s,
        logic [3:0][VERTEX_ID_BITS-1:0] cv,
        logic [3:0][VERTEX_ID_BITS-1:0] mv
    );
        return s.is_mid ? mv[s.idx] : cv[s.idx];
    endfunction

    assign pattern = tves_pkg::t_pattern'(i_data[PB-1:0]);
    assign corners = i_data[PB +: VB];
    assign mids    = i_data[PB+VB +: VB];
    assign tmpl    = tves_pkg::prim_template(pattern, r_step);

    assign load  = i_q_status.not_empty && (!r_valid || !i_stall);
    assign o_pop = load && tmpl.last;

    always_comb begin
        n_step = r_step;
        if (load) begin
            n_step = tmpl.last ? '0 : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quad <= tmpl.is_quad;
            r_a    <= pick(tmpl.sel_a, corners, mids);
            r_b    <= pick(tmpl.sel_b, corners, mids);
            r_c    <= pick(tmpl.sel_c, corners, mids);
            r_d    <= tmpl.is_quad ? pick(tmpl.sel_d, corners, mids) : '0;
            r_last <= tmpl.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_prim_is_quad = r_quad;
    assign o_vert_a       = r_a;
    assign o_vert_b       = r_b;
    assign o_vert_c       = r_c;
    assign o_vert_d       = r_d;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ----- hdl/tves_checker.sv -----
// Port-level checker for the T-vertex splitter and the bind that attaches
// it to tvertex_elimination_split_top. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tves_checker #(
    parameter int VERTEX_ID_BITS = 16
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic                      o_prim_is_quad,
    input wire logic [VERTEX_ID_BITS-1:0] o_vert_a,
    input wire logic [VERTEX_ID_BITS-1:0] o_vert_b,
    input wire logic [VERTEX_ID_BITS-1:0] o_vert_c,
    input wire logic [VERTEX_ID_BITS-1:0] o_vert_d,
    input wire logic                      o_last
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid set after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prim_is_quad) && $stable(o_vert_a)
            && $stable(o_vert_b) && $stable(o_vert_c) && $stable(o_vert_d)
            && $stable(o_last))
        else $error("stalled result changed");

    a_triangle_d_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_prim_is_quad |-> o_vert_d == '0)
        else $error("triangle carries a fourth vertex");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("primitive run of an element broken");

endmodule

bind tvertex_elimination_split_top tves_checker #(
    .VERTEX_ID_BITS(VERTEX_ID_BITS)
) u_tves_checker (.*);

`default_nettype wire
